// ===== sv/sec_pkg.sv =====
// Shared types, constants and helper function of the soil conductivity block.
package sec_pkg;

   localparam int DEPTH_W = 26;
   localparam int LEN_W   = 24;
   localparam int RES_W   = 40;
   localparam int DVD_W   = 36;
   localparam int LOG_W   = 22;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
   localparam logic [RES_W-1:0]   RES_MAX   = '1;
   localparam logic [15:0] ICE_Q12        = 16'd9011;
   localparam logic [16:0] ONE_Q16        = 17'd65536;
   localparam logic [16:0] SR_KERSTEN_MIN = 17'd6553;
   localparam logic [17:0] LOG10_2_Q16    = 18'd19728;
   localparam logic [17:0] EXP_C3         = 18'd5121;
   localparam logic [16:0] EXP_C2         = 17'd14823;
   localparam logic [16:0] EXP_C1         = 17'd45584;
   localparam logic [15:0] EFF_MAX        = 16'hFFFF;

   localparam logic [1:0] CSR_TOP    = 2'd0;
   localparam logic [1:0] CSR_BOTTOM = 2'd1;
   localparam logic [1:0] CSR_WATER  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_LAYER = 2'd1;
   localparam logic [1:0] ST_FAULT    = 2'd2;

   typedef struct packed {
      logic [23:0] top_depth;
      logic [23:0] bottom_depth;
      logic [15:0] water_conductivity;
   } sec_cfg_type;

   typedef struct packed {
      logic [15:0]      dry;
      logic [15:0]      solids;
      logic [15:0]      moist;
      logic [15:0]      poro;
      logic             frozen;
      logic             use_layer;
      logic [LEN_W-1:0] clipped;
      logic             last;
      logic             started;
      logic             gap_valid;
      logic [LEN_W-1:0] gap;
      logic [LEN_W-1:0] total;
   } sec_job_type;

   typedef enum logic [4:0] {
      B_IDLE, B_LAYER, B_DIV, B_SR, B_LOG0, B_LOG, B_LS, B_LF, B_EX,
      B_P1, B_P2, B_P3, B_KE, B_KL, B_K, B_ADD, B_LAST, B_FIN, B_EFF, B_OUT
   } sec_state_type;

   // Position of the leading one of a 17-bit value (0 for zero).
   function automatic logic [4:0] lead_one(input logic [16:0] x);
      logic [4:0] pos;
      pos = '0;
      for (int b = 0; b < 17; b++) begin
         if (x[b]) pos = 5'(b);
      end
      return pos;
   endfunction

endpackage

// ===== sv/sec_if.sv =====
// Request and response channel interfaces.
interface sec_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] layer_thickness;
   logic [15:0] dry_conductivity;
   logic [15:0] solids_conductivity;
   logic [15:0] moisture_fraction;
   logic [15:0] porosity_fraction;
   logic signed [15:0] soil_temperature;
   logic        last_layer;

   modport source (output valid, layer_thickness, dry_conductivity, solids_conductivity,
                   moisture_fraction, porosity_fraction, soil_temperature, last_layer,
                   input ready);
   modport sink (input valid, layer_thickness, dry_conductivity, solids_conductivity,
                 moisture_fraction, porosity_fraction, soil_temperature, last_layer,
                 output ready);
endinterface

interface sec_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] effective_conductivity;
   logic [1:0]  status;

   modport source (output valid, effective_conductivity, status, input ready);
   modport sink (input valid, effective_conductivity, status, output ready);
endinterface

// ===== sv/sec_front.sv =====
// Front end: tracks profile depth, clips each layer to the interval and queues the job.
module sec_front
   import sec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sec_req_if.sink     req,
   input  sec_cfg_type cfg,
   input  logic        full,
   output logic        push,
   output sec_job_type job
);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               started_ff, started_in;
   logic               ended_ff, ended_in;

   logic [DEPTH_W:0]   depth_sum;
   logic [DEPTH_W-1:0] depth_new;
   logic [DEPTH_W-1:0] top_w, bot_w, lo;

   assign req.ready = !full;
   assign push      = req.valid && req.ready;
   assign top_w     = DEPTH_W'(cfg.top_depth);
   assign bot_w     = DEPTH_W'(cfg.bottom_depth);

   always_comb begin
      depth_sum  = {1'b0, depth_ff} + (DEPTH_W+1)'(req.layer_thickness);
      depth_new  = depth_sum[DEPTH_W] ? DEPTH_MAX : depth_sum[DEPTH_W-1:0];
      lo         = (depth_new < bot_w) ? depth_new : bot_w;
      depth_in   = depth_ff;
      started_in = started_ff;
      ended_in   = ended_ff;

      job.dry       = req.dry_conductivity;
      job.solids    = req.solids_conductivity;
      job.moist     = req.moisture_fraction;
      job.poro      = req.porosity_fraction;
      job.frozen    = req.soil_temperature[15];
      job.use_layer = 1'b0;
      job.clipped   = '0;
      job.last      = req.last_layer;

      if (!ended_ff) begin
         depth_in = depth_new;
         if (depth_new > top_w) begin
            job.use_layer = 1'b1;
            if (!started_ff) begin
               started_in  = 1'b1;
               job.clipped = (lo > top_w) ? LEN_W'(lo - top_w) : '0;
               if (depth_new > bot_w) ended_in = 1'b1;
            end else if (depth_new > bot_w) begin
               job.clipped = (bot_w > depth_ff) ? LEN_W'(bot_w - depth_ff) : '0;
               ended_in    = 1'b1;
            end else begin
               job.clipped = req.layer_thickness;
            end
         end
      end

      job.started   = started_in;
      job.gap_valid = started_in && !ended_in && (bot_w > depth_in);
      job.gap       = LEN_W'(bot_w - depth_in);
      job.total     = (cfg.bottom_depth > cfg.top_depth) ?
                      (cfg.bottom_depth - cfg.top_depth) : '0;

      // Start a fresh profile after the deepest layer.
      if (req.last_layer) begin
         depth_in   = '0;
         started_in = 1'b0;
         ended_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         started_ff <= 1'b0;
         ended_ff   <= 1'b0;
      end else if (push) begin
         depth_ff   <= depth_in;
         started_ff <= started_in;
         ended_ff   <= ended_in;
      end
   end

endmodule

// ===== sv/sec_queue.sv =====
// Short job queue between the front and back ends.
module sec_queue
   import sec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  sec_job_type job_in,
   output logic        full,
   output logic        not_empty,
   input  logic        pop,
   output sec_job_type job_out
);

   sec_job_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, rd_ff;
   logic [QPTR_W:0]       cnt_ff;

   assign full      = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign job_out   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= job_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
      end
   end

endmodule

// ===== sv/sec_back.sv =====
// Back end: Johansen conductivity, resistance sum and result on one shared multiplier and divider.
module sec_back
   import sec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  sec_job_type job,
   output logic        pop,
   input  logic [15:0] water,
   sec_rsp_if.source   rsp
);

   sec_state_type state_ff, state_in, ret_ff, ret_in;
   sec_job_type   job_ff, job_in;

   logic [16:0] sr_ff, sr_in;
   logic [15:0] sat_ff, sat_in;
   logic [16:0] ke_ff, ke_in;
   logic signed [LOG_W-1:0] ls_ff, ls_in, lg_ff, lg_in;
   logic signed [40:0] acc_ff, acc_in;
   logic signed [24:0] ex_ff, ex_in;
   logic [16:0] p_ff, p_in;
   logic [16:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [4:0]  le_ff, le_in;
   logic [15:0] lfrac_ff, lfrac_in;
   logic [3:0]  lcnt_ff, lcnt_in;
   logic        lfb16_ff, lfb16_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0] dq_ff, dq_in;
   logic [RES_W:0]   dr_ff, dr_in;
   logic [RES_W-1:0] dd_ff, dd_in;
   logic [RES_W-1:0] rsum_ff, rsum_in;
   logic [15:0] bk_ff, bk_in;
   logic        fault_ff, fault_in;
   logic        gap_ph_ff, gap_ph_in;
   logic [15:0] pend_eff_ff, pend_eff_in;
   logic [1:0]  pend_st_ff, pend_st_in;
   logic        rv_ff, rv_in;
   logic [15:0] out_eff_ff, out_eff_in;
   logic [1:0]  out_st_ff, out_st_in;

   logic signed [17:0] mul_a;
   logic signed [22:0] mul_b;
   logic signed [40:0] mul_p;

   logic [15:0]        filler;
   logic signed [40:0] ex_sum;
   logic [17:0]        sq;
   logic [15:0]        frac_new;
   logic signed [5:0]  exp_i;
   logic [17:0]        m_val, m_sh;
   logic signed [9:0]  sh;
   logic signed [25:0] kl_v;
   logic signed [19:0] k_v;
   logic signed [16:0] sat_diff;
   logic [RES_W:0]     div_r, add_sum;
   logic [15:0]        k_new;

   assign rsp.valid                  = rv_ff;
   assign rsp.effective_conductivity = out_eff_ff;
   assign rsp.status                 = out_st_ff;
   assign filler   = job_ff.frozen ? ICE_Q12 : water;
   assign sat_diff = $signed({1'b0, sat_ff}) - $signed({1'b0, job_ff.dry});
   assign mul_p    = mul_a * mul_b;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         B_LOG: begin
            mul_a = $signed({1'b0, ly_ff});
            mul_b = $signed({6'b0, ly_ff});
         end
         B_LF: begin
            mul_a = $signed({1'b0, 17'(ONE_Q16 - {1'b0, job_ff.poro})});
            mul_b = 23'(ls_ff);
         end
         B_EX: begin
            mul_a = $signed({2'b0, job_ff.poro});
            mul_b = 23'(lg_ff);
         end
         B_P1: begin
            mul_a = $signed(EXP_C3);
            mul_b = $signed({7'b0, ex_ff[15:0]});
         end
         B_P2, B_P3: begin
            mul_a = $signed({1'b0, p_ff});
            mul_b = $signed({7'b0, ex_ff[15:0]});
         end
         B_KL: begin
            mul_a = $signed(LOG10_2_Q16);
            mul_b = 23'(lg_ff);
         end
         B_K: begin
            mul_a = 18'(sat_diff);
            mul_b = $signed({6'b0, ke_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      job_in      = job_ff;
      sr_in       = sr_ff;
      sat_in      = sat_ff;
      ke_in       = ke_ff;
      ls_in       = ls_ff;
      lg_in       = lg_ff;
      acc_in      = acc_ff;
      ex_in       = ex_ff;
      p_in        = p_ff;
      lx_in       = lx_ff;
      ly_in       = ly_ff;
      le_in       = le_ff;
      lfrac_in    = lfrac_ff;
      lcnt_in     = lcnt_ff;
      lfb16_in    = lfb16_ff;
      cnt_in      = cnt_ff;
      dq_in       = dq_ff;
      dr_in       = dr_ff;
      dd_in       = dd_ff;
      rsum_in     = rsum_ff;
      bk_in       = bk_ff;
      fault_in    = fault_ff;
      gap_ph_in   = gap_ph_ff;
      pend_eff_in = pend_eff_ff;
      pend_st_in  = pend_st_ff;
      rv_in       = rv_ff && !rsp.ready;
      out_eff_in  = out_eff_ff;
      out_st_in   = out_st_ff;
      pop         = 1'b0;

      ex_sum   = acc_ff + mul_p;
      sq       = mul_p[33:16];
      frac_new = lfrac_ff;
      if (sq[17]) frac_new[lcnt_ff] = 1'b1;
      exp_i    = ex_ff[21:16];
      m_val    = 18'(ONE_Q16) + mul_p[33:16];
      sh       = 10'sd4 - 10'(exp_i);
      m_sh     = m_val >> sh[4:0];
      kl_v     = 26'(mul_p >>> 16) + 26'sd65536;
      k_v      = 20'(mul_p >>> 16) + $signed({4'b0, job_ff.dry});
      k_new    = (k_v < 0) ? 16'd0 : ((k_v > 20'sd65535) ? EFF_MAX : k_v[15:0]);
      div_r    = {dr_ff[RES_W-1:0], dq_ff[DVD_W-1]};
      add_sum  = {1'b0, rsum_ff} + (RES_W+1)'(dq_ff);

      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               job_in   = job;
               state_in = B_LAYER;
            end
         end
         B_LAYER: begin
            if (!job_ff.use_layer) begin
               state_in = B_LAST;
            end else if (job_ff.poro == '0) begin
               fault_in = 1'b1;
               bk_in    = '0;
               state_in = B_LAST;
            end else begin
               dq_in    = {4'b0, job_ff.moist, 16'b0};
               dd_in    = RES_W'(job_ff.poro);
               dr_in    = '0;
               cnt_in   = 6'(DVD_W);
               ret_in   = B_SR;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (div_r >= {1'b0, dd_ff}) begin
               dr_in = div_r - {1'b0, dd_ff};
               dq_in = {dq_ff[DVD_W-2:0], 1'b1};
            end else begin
               dr_in = div_r;
               dq_in = {dq_ff[DVD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) state_in = ret_ff;
         end
         B_SR: begin
            sr_in = (dq_ff > DVD_W'(ONE_Q16)) ? ONE_Q16 : dq_ff[16:0];
            if (job_ff.solids == '0 || filler == '0) begin
               sat_in   = '0;
               state_in = B_KE;
            end else begin
               lx_in    = {1'b0, job_ff.solids};
               lfb16_in = 1'b0;
               ret_in   = B_LS;
               state_in = B_LOG0;
            end
         end
         B_LOG0: begin
            le_in    = lead_one(lx_ff);
            ly_in    = 17'(lx_ff << (5'd16 - lead_one(lx_ff)));
            lfrac_in = '0;
            lcnt_in  = 4'd15;
            state_in = B_LOG;
         end
         B_LOG: begin
            // Square, renormalise and take one fraction bit.
            ly_in    = sq[17] ? sq[17:1] : sq[16:0];
            lfrac_in = frac_new;
            lcnt_in  = lcnt_ff - 1'b1;
            if (lcnt_ff == '0) begin
               lg_in    = {$signed({1'b0, le_ff}) - (lfb16_ff ? 6'sd16 : 6'sd12), frac_new};
               state_in = ret_ff;
            end
         end
         B_LS: begin
            ls_in    = lg_ff;
            lx_in    = {1'b0, filler};
            lfb16_in = 1'b0;
            ret_in   = B_LF;
            state_in = B_LOG0;
         end
         B_LF: begin
            acc_in   = mul_p;
            state_in = B_EX;
         end
         B_EX: begin
            ex_in    = 25'(ex_sum >>> 16);
            state_in = B_P1;
         end
         B_P1: begin
            p_in     = EXP_C2 + mul_p[32:16];
            state_in = B_P2;
         end
         B_P2: begin
            p_in     = EXP_C1 + mul_p[32:16];
            state_in = B_P3;
         end
         B_P3: begin
            if (sh <= 0)
               sat_in = EFF_MAX;
            else if (sh >= 10'sd32)
               sat_in = '0;
            else
               sat_in = (m_sh > 18'(EFF_MAX)) ? EFF_MAX : m_sh[15:0];
            state_in = B_KE;
         end
         B_KE: begin
            if (job_ff.frozen) begin
               ke_in    = sr_ff;
               state_in = B_K;
            end else if (sr_ff > SR_KERSTEN_MIN) begin
               lx_in    = sr_ff;
               lfb16_in = 1'b1;
               ret_in   = B_KL;
               state_in = B_LOG0;
            end else begin
               ke_in    = '0;
               state_in = B_K;
            end
         end
         B_KL: begin
            if (kl_v < 0)
               ke_in = '0;
            else if (kl_v > 26'sd65536)
               ke_in = ONE_Q16;
            else
               ke_in = kl_v[16:0];
            state_in = B_K;
         end
         B_K: begin
            bk_in = k_new;
            if (k_new == '0) begin
               fault_in = 1'b1;
               state_in = B_LAST;
            end else begin
               dq_in    = {job_ff.clipped, 12'b0};
               dd_in    = RES_W'(k_new);
               dr_in    = '0;
               cnt_in   = 6'(DVD_W);
               ret_in   = B_ADD;
               state_in = B_DIV;
            end
         end
         B_ADD: begin
            rsum_in  = add_sum[RES_W] ? RES_MAX : add_sum[RES_W-1:0];
            state_in = gap_ph_ff ? B_FIN : B_LAST;
         end
         B_LAST: begin
            if (!job_ff.last) begin
               state_in = B_IDLE;
            end else if (!job_ff.started) begin
               pend_eff_in = '0;
               pend_st_in  = ST_NO_LAYER;
               state_in    = B_OUT;
            end else if (job_ff.gap_valid) begin
               // Extend the bottom layer down to the interval bottom.
               if (bk_ff == '0) begin
                  fault_in = 1'b1;
                  state_in = B_FIN;
               end else begin
                  gap_ph_in = 1'b1;
                  dq_in     = {job_ff.gap, 12'b0};
                  dd_in     = RES_W'(bk_ff);
                  dr_in     = '0;
                  cnt_in    = 6'(DVD_W);
                  ret_in    = B_ADD;
                  state_in  = B_DIV;
               end
            end else begin
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (fault_ff || job_ff.total == '0) begin
               pend_eff_in = '0;
               pend_st_in  = ST_FAULT;
               state_in    = B_OUT;
            end else if (rsum_ff == '0) begin
               pend_eff_in = EFF_MAX;
               pend_st_in  = ST_OK;
               state_in    = B_OUT;
            end else begin
               dq_in    = {job_ff.total, 12'b0};
               dd_in    = rsum_ff;
               dr_in    = '0;
               cnt_in   = 6'(DVD_W);
               ret_in   = B_EFF;
               state_in = B_DIV;
            end
         end
         B_EFF: begin
            pend_eff_in = (dq_ff > DVD_W'(EFF_MAX)) ? EFF_MAX : dq_ff[15:0];
            pend_st_in  = ST_OK;
            state_in    = B_OUT;
         end
         B_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in      = 1'b1;
               out_eff_in = pend_eff_ff;
               out_st_in  = pend_st_ff;
               rsum_in    = '0;
               bk_in      = '0;
               fault_in   = 1'b0;
               gap_ph_in  = 1'b0;
               state_in   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         ret_ff    <= B_IDLE;
         rv_ff     <= 1'b0;
         rsum_ff   <= '0;
         bk_ff     <= '0;
         fault_ff  <= 1'b0;
         gap_ph_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         rv_ff     <= rv_in;
         rsum_ff   <= rsum_in;
         bk_ff     <= bk_in;
         fault_ff  <= fault_in;
         gap_ph_ff <= gap_ph_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sr_ff       <= sr_in;
      sat_ff      <= sat_in;
      ke_ff       <= ke_in;
      ls_ff       <= ls_in;
      lg_ff       <= lg_in;
      acc_ff      <= acc_in;
      ex_ff       <= ex_in;
      p_ff        <= p_in;
      lx_ff       <= lx_in;
      ly_ff       <= ly_in;
      le_ff       <= le_in;
      lfrac_ff    <= lfrac_in;
      lcnt_ff     <= lcnt_in;
      lfb16_ff    <= lfb16_in;
      cnt_ff      <= cnt_in;
      dq_ff       <= dq_in;
      dr_ff       <= dr_in;
      dd_ff       <= dd_in;
      pend_eff_ff <= pend_eff_in;
      pend_st_ff  <= pend_st_in;
      out_eff_ff  <= out_eff_in;
      out_st_ff   <= out_st_in;
   end

endmodule

// ===== sv/soil_effective_conductivity_unit.sv =====
// Top level of the soil effective conductivity unit.
// Layers of one soil profile enter top down on req_ch, one transfer per layer;
// the layer flagged last_layer closes the profile and yields one transfer on
// rsp_ch with the series effective conductivity and a status code. Other
// layers yield nothing. Registers are written through csr_wr_en, csr_index
// and csr_wdata while the unit is idle; the user must keep to this, as the
// block itself does not enforce it. The front end takes a layer and clips it
// to the depth interval; a two-entry queue lets it run ahead of the back end.
// The back end skips the computation for a layer outside the interval or with
// zero porosity (a fault); for one inside it, it uses a 36-step restoring
// divider for saturation and resistance and up to three log2 passes on the
// shared multiplier. The last layer adds up to two more divides and a step into
// the output register. rsp_ch is registered: a stalled receiver holds the
// result while the front keeps filling the queue, and the back end waits only
// when it has a second result ready. Reset is synchronous: it empties the queue,
// clears the profile state and restores the register defaults.
module soil_effective_conductivity_unit
   import sec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sec_req_if.sink     req_ch,
   sec_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   sec_cfg_type cfg_ff;
   sec_job_type f_job, q_job;
   logic        q_push, q_full, q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_depth          <= 24'd0;
         cfg_ff.bottom_depth       <= 24'd65536;
         cfg_ff.water_conductivity <= 16'd2335;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TOP:    cfg_ff.top_depth          <= csr_wdata;
            CSR_BOTTOM: cfg_ff.bottom_depth       <= csr_wdata;
            CSR_WATER:  cfg_ff.water_conductivity <= csr_wdata[15:0];
            default:    ;
         endcase
      end
   end

   sec_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .cfg   (cfg_ff),
      .full  (q_full),
      .push  (q_push),
      .job   (f_job)
   );

   sec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .job_in    (f_job),
      .full      (q_full),
      .not_empty (q_valid),
      .pop       (q_pop),
      .job_out   (q_job)
   );

   sec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job       (q_job),
      .pop       (q_pop),
      .water     (cfg_ff.water_conductivity),
      .rsp       (rsp_ch)
   );

   a_no_layer_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_NO_LAYER) |-> rsp_ch.effective_conductivity == '0)
      else $error("no-layer result carries a nonzero conductivity");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == ST_FAULT) |-> rsp_ch.effective_conductivity == '0)
      else $error("fault result carries a nonzero conductivity");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid straight after reset");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

endmodule

// ===== dv/soil_effective_conductivity_unit_tb.sv =====
// Self-checking testbench of the soil effective conductivity unit.
`timescale 1ns / 1ps

module soil_effective_conductivity_unit_tb;
   import sec_pkg::*;

   typedef struct packed {
      logic [23:0]        thick;
      logic [15:0]        dry;
      logic [15:0]        solids;
      logic [15:0]        moist;
      logic [15:0]        poro;
      logic signed [15:0] temp;
      logic               last;
      logic               typed;
      logic [15:0]        eff;
      logic [1:0]         st;
   } layer_row_type;

   typedef struct packed {
      logic [15:0] eff;
      logic [1:0]  st;
   } profile_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_TOP;
   logic [23:0] csr_wdata = '0;

   sec_req_if req_ch ();
   sec_rsp_if rsp_ch ();

   soil_effective_conductivity_unit uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Conductivity predictor state
   longint unsigned top_m, bottom_m, water_m;
   longint unsigned depth_acc, res_acc, deep_k;
   bit started_f, ended_f, fault_f;

   profile_result_type results_due[$];
   int errors = 0;
   bit hold_req = 1'b0;
   bit hold_taken = 1'b0;
   bit quiet = 1'b0;

   task automatic report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic longint log2_fix(input longint unsigned x, input int fb);
      int e;
      longint unsigned y, frac, b;
      e = 0;
      frac = 0;
      while (e < 62 && (x >> (e + 1)) != 0) e++;
      y = (e >= 16) ? (x >> (e - 16)) : (x << (16 - e));
      for (b = 32768; b != 0; b >>= 1) begin
         y = (y * y) >> 16;
         if (y >= 131072) begin
            y >>= 1;
            frac |= b;
         end
      end
      return (longint'(e) - fb) * 65536 + longint'(frac);
   endfunction

   function automatic longint unsigned pow2_q12(input longint ex);
      longint i, sh;
      longint unsigned f, p, m;
      i = ex >>> 16;
      f = longint'(ex - i * 65536);
      p = 5121;
      p = 14823 + ((p * f) >> 16);
      p = 45584 + ((p * f) >> 16);
      m = 65536 + ((p * f) >> 16);
      sh = 4 - i;
      if (sh <= 0) return 65535;
      if (sh >= 32) return 0;
      m >>= sh;
      return (m > 65535) ? 65535 : m;
   endfunction

   function automatic longint unsigned johansen_k(input layer_row_type r, output bit bad);
      longint unsigned n, sr, sat, ke, filler;
      longint ls, lf, ex, v, k;
      bit frozen;
      bad = 1'b0;
      n = r.poro;
      frozen = r.temp[15];
      filler = frozen ? ICE_Q12 : water_m;
      if (n == 0) begin
         bad = 1'b1;
         return 0;
      end
      sr = (longint'(r.moist) << 16) / n;
      if (sr > 65536) sr = 65536;
      if (r.solids == 0 || filler == 0) sat = 0;
      else begin
         ls = log2_fix(r.solids, 12);
         lf = log2_fix(filler, 12);
         ex = ((65536 - longint'(n)) * ls + longint'(n) * lf) >>> 16;
         sat = pow2_q12(ex);
      end
      if (frozen) ke = sr;
      else if (sr > 6553) begin
         v = 65536 + ((log2_fix(sr, 16) * 19728) >>> 16);
         ke = (v < 0) ? 0 : ((v > 65536) ? 65536 : v);
      end else ke = 0;
      k = longint'(r.dry) + (((longint'(sat) - longint'(r.dry)) * longint'(ke)) >>> 16);
      if (k < 0) k = 0;
      if (k > 65535) k = 65535;
      if (k == 0) bad = 1'b1;
      return k;
   endfunction

   function automatic void add_res(input longint unsigned len, input longint unsigned k);
      if (k == 0) begin
         fault_f = 1'b1;
         return;
      end
      res_acc += (len << 12) / k;
      if (res_acc > RES_MAX) res_acc = RES_MAX;
   endfunction

   function automatic void clear_profile();
      depth_acc = 0;
      res_acc = 0;
      deep_k = 0;
      started_f = 0;
      ended_f = 0;
      fault_f = 0;
   endfunction

   function automatic bit series_conductivity(input layer_row_type r,
                                              output profile_result_type res);
      longint unsigned prev, clipped, lo, k, total, eff;
      bit bad;
      prev = depth_acc;
      res = '0;
      if (!ended_f) begin
         depth_acc = prev + r.thick;
         if (depth_acc > DEPTH_MAX) depth_acc = DEPTH_MAX;
         if (depth_acc > top_m) begin
            if (!started_f) begin
               lo = (depth_acc < bottom_m) ? depth_acc : bottom_m;
               started_f = 1;
               clipped = (lo > top_m) ? lo - top_m : 0;
               if (depth_acc > bottom_m) ended_f = 1;
            end else if (depth_acc > bottom_m) begin
               clipped = (bottom_m > prev) ? bottom_m - prev : 0;
               ended_f = 1;
            end else clipped = r.thick;
            k = johansen_k(r, bad);
            deep_k = k;
            if (bad) fault_f = 1;
            else add_res(clipped, k);
         end
      end
      if (!r.last) return 0;
      res.st = ST_OK;
      if (!started_f) res.st = ST_NO_LAYER;
      else begin
         if (!ended_f && bottom_m > depth_acc) add_res(bottom_m - depth_acc, deep_k);
         total = (bottom_m > top_m) ? bottom_m - top_m : 0;
         if (fault_f || total == 0) res.st = ST_FAULT;
         else if (res_acc == 0) res.eff = EFF_MAX;
         else begin
            eff = (total << 12) / res_acc;
            res.eff = (eff > 65535) ? EFF_MAX : eff[15:0];
         end
      end
      clear_profile();
      return 1;
   endfunction

   // Response side: check every transfer, then pick the next ready level
   int stall_left = 0;
   always @(posedge clock) begin
      profile_result_type want;
      if (reset) rsp_ch.ready <= 1'b0;
      else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) report("result with nothing expected");
            else begin
               want = results_due.pop_front();
               if (rsp_ch.effective_conductivity !== want.eff)
                  report($sformatf("effective_conductivity %0d, expected %0d",
                                   rsp_ch.effective_conductivity, want.eff));
               if (rsp_ch.status !== want.st)
                  report($sformatf("status %0d, expected %0d", rsp_ch.status, want.st));
            end
         end
         // Hold off once for a long stretch so that the block fills up
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = 3000;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (quiet || $urandom_range(0, 9) < 7) rsp_ch.ready <= 1'b1;
         else begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 3);
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   int sent = 0;

   task automatic send(input layer_row_type r);
      profile_result_type res;
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.layer_thickness <= r.thick;
      req_ch.dry_conductivity <= r.dry;
      req_ch.solids_conductivity <= r.solids;
      req_ch.moisture_fraction <= r.moist;
      req_ch.porosity_fraction <= r.poro;
      req_ch.soil_temperature <= r.temp;
      req_ch.last_layer <= r.last;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      if (series_conductivity(r, res)) begin
         if (r.typed && (res.eff !== r.eff || res.st !== r.st))
            report($sformatf("typed row disagrees with prediction (%0d/%0d)", res.eff, res.st));
         results_due.push_back(r.typed ? profile_result_type'({r.eff, r.st}) : res);
      end
      if (sent == 200) hold_req = 1'b1;
      quiet = (sent >= 500 && sent < 560);
      gap = 0;
      if (!quiet && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (sent == 400) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (results_due.size() != 0);
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_TOP:    top_m = val;
         CSR_BOTTOM: bottom_m = val;
         CSR_WATER:  water_m = val[15:0];
         default: ;
      endcase
   endtask

   function automatic layer_row_type random_layer(input bit noise, input bit last);
      layer_row_type r;
      longint unsigned reach;
      r = '0;
      r.dry = 16'($urandom);
      r.solids = 16'($urandom);
      r.poro = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
      r.moist = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, r.poro));
      r.temp = 16'($urandom);
      reach = (bottom_m > 4) ? bottom_m / 3 + 1 : 65536;
      if (reach > 24'hFFFFFF) reach = 24'hFFFFFF;
      if (noise || $urandom_range(0, 9) == 0) r.thick = 24'($urandom);
      else if ($urandom_range(0, 19) == 0) r.thick = '0;
      else r.thick = 24'($urandom_range(1, 32'(reach)));
      r.last = noise ? 1'($urandom) : last;
      return r;
   endfunction

   // Directed rows under the reset register values (top 0, bottom 1.0 m)
   layer_row_type directed [] = '{
      '{24'd0, 16'd1000, 16'd12000, 16'h8000, 16'h8000, 16'sd5120, 1'b1, 1'b1, 16'd0, ST_NO_LAYER},
      '{24'd65536, 16'd1000, 16'd12000, 16'h8000, 16'h8000, 16'sd5120, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd65536, 16'd1000, 16'd12000, 16'h8000, 16'h8000, -16'sd256, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd32768, 16'd1000, 16'd12000, 16'h8000, 16'd0, 16'sd5120, 1'b1, 1'b1, 16'd0, ST_FAULT},
      '{24'd65536, 16'd0, 16'd0, 16'd0, 16'h8000, 16'sd5120, 1'b1, 1'b1, 16'd0, ST_FAULT},
      '{24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh8000, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd16384, 16'd800, 16'd9000, 16'h4000, 16'h6000, 16'sd2560, 1'b0, 1'b0, 16'd0, ST_OK},
      '{24'd16384, 16'd900, 16'd20000, 16'h2000, 16'h5000, -16'sd2560, 1'b0, 1'b0, 16'd0, ST_OK},
      '{24'd16384, 16'd700, 16'd15000, 16'h3000, 16'h7000, 16'sd100, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd40000, 16'd800, 16'd9000, 16'h4000, 16'h6000, 16'sd2560, 1'b0, 1'b0, 16'd0, ST_OK},
      '{24'd40000, 16'd900, 16'd20000, 16'h2000, 16'h5000, 16'sd2560, 1'b0, 1'b0, 16'd0, ST_OK},
      '{24'd50000, 16'd0, 16'd0, 16'd0, 16'd0, 16'sd2560, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd65536, 16'd1200, 16'd12000, 16'd100, 16'hFFFF, 16'sd5120, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd65536, 16'd1200, 16'd12000, 16'hFFFF, 16'h1000, 16'sd5120, 1'b1, 1'b0, 16'd0, ST_OK},
      '{24'd65536, 16'd1200, 16'd0, 16'h8000, 16'h8000, -16'sd1, 1'b1, 1'b0, 16'd0, ST_OK}
   };

   // Register settings per phase: top, bottom, water
   logic [23:0] phase_cfg [6][3] = '{
      '{24'd0, 24'hFFFFFF, 24'd65535},
      '{24'hFFFFFF, 24'hFFFFFF, 24'd1},
      '{24'd131072, 24'd65536, 24'd2335},
      '{24'd0, 24'd1, 24'd40000},
      '{24'd32768, 24'd327680, 24'd1000},
      '{24'd0, 24'd65536, 24'd2335}
   };

   initial begin
      int n_layers, target;
      bit noise;
      req_ch.valid = 1'b0;
      req_ch.layer_thickness = '0;
      req_ch.dry_conductivity = '0;
      req_ch.solids_conductivity = '0;
      req_ch.moisture_fraction = '0;
      req_ch.porosity_fraction = '0;
      req_ch.soil_temperature = '0;
      req_ch.last_layer = 1'b0;
      rsp_ch.ready = 1'b0;
      top_m = 0;
      bottom_m = 65536;
      water_m = 2335;
      clear_profile();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send(directed[i]);
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         write_csr(CSR_TOP, phase_cfg[ph][0]);
         write_csr(CSR_BOTTOM, phase_cfg[ph][1]);
         write_csr(CSR_WATER, phase_cfg[ph][2]);
         target = sent + 140;
         while (sent < target) begin
            noise = ($urandom_range(0, 9) == 0);
            n_layers = $urandom_range(1, 5);
            for (int l = 0; l < n_layers; l++)
               send(random_layer(noise, l == n_layers - 1));
         end
         // close any profile left open by noise
         send(random_layer(1'b0, 1'b1));
      end
      drain();
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
